>>> design/gxpc_pkg.sv
// Package for the group XOR parity chunker: field widths, configuration
// register indexes and their reset values. No dependencies.
`default_nettype none

package gxpc_pkg;

	// Default parity memory depth, the largest chunk in bytes.
	localparam int MAX_CHUNK_DEFAULT = 9000;

	// Payload and register widths.
	localparam int BYTE_W   = 8;
	localparam int OFF_W    = 14;
	localparam int CPG_W    = 16;
	localparam int CHUNK_W  = 32;
	localparam int GROUP_W  = 32;
	localparam int POS_W    = 40;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 40;

	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_BYTES      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHUNKS_PER_GROUP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_TOTAL      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FILE_LENGTH      = 2'd3;

	localparam logic [OFF_W-1:0]   CHUNK_BYTES_RST      = 14'd1024;
	localparam logic [CPG_W-1:0]   CHUNKS_PER_GROUP_RST = 16'd8;
	localparam logic [CHUNK_W-1:0] CHUNK_TOTAL_RST      = 32'd0;
	localparam logic [POS_W-1:0]   FILE_LENGTH_RST      = 40'd0;

endpackage : gxpc_pkg

`default_nettype wire

>>> design/gxpc_if.sv
// Valid/ready channel interfaces for the chunker: the file byte stream in
// and the data/parity result stream out. Depends on gxpc_pkg.
`default_nettype none

interface gxpc_in_if import gxpc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] file_byte;

	modport source (output valid, output file_byte, input ready);
	modport sink (input valid, input file_byte, output ready);
endinterface : gxpc_in_if

interface gxpc_out_if import gxpc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               data_valid;
	logic [BYTE_W-1:0]  data_out;
	logic [CHUNK_W-1:0] chunk_number;
	logic [OFF_W-1:0]   byte_offset;
	logic               data_end;
	logic               parity_valid;
	logic [BYTE_W-1:0]  parity_out;
	logic [GROUP_W-1:0] group_number;
	logic               parity_end;

	modport source (output valid, output data_valid, output data_out, output chunk_number,
		output byte_offset, output data_end, output parity_valid, output parity_out,
		output group_number, output parity_end, input ready);
	modport sink (input valid, input data_valid, input data_out, input chunk_number,
		input byte_offset, input data_end, input parity_valid, input parity_out,
		input group_number, input parity_end, output ready);
endinterface : gxpc_out_if

`default_nettype wire

>>> design/group_xor_parity_chunker.sv
// A byte taken in is held in stage 1 for the memory read, then in the output register.
// Throughput: one byte per cycle unless res_out stalls; the parity memory does one read
// and one write per cycle; a write-to-read forward covers back-to-back same-offset bytes.
// Reset: arst_n clears counters, pipeline valids and loads register reset values; the
// parity memory is not cleared, since the first chunk of each group overwrites it.
`default_nettype none

module group_xor_parity_chunker import gxpc_pkg::*; #(
	parameter int MAX_CHUNK = MAX_CHUNK_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	gxpc_in_if.sink                    byte_in,
	gxpc_out_if.source                 res_out,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int AW  = $clog2(MAX_CHUNK);
	localparam int CBW = $clog2(MAX_CHUNK + 1);
	localparam int CW  = (CBW > OFF_W) ? CBW : OFF_W;
	localparam logic [CW-1:0] CB_MAX  = CW'(MAX_CHUNK);
	localparam logic [CW-1:0] OFF_MAX = CW'(MAX_CHUNK - 1);

	// Configuration registers.
	logic [OFF_W-1:0]   chunk_bytes_q;
	logic [CPG_W-1:0]   chunks_per_group_q;
	logic [CHUNK_W-1:0] chunk_total_q;
	logic [POS_W-1:0]   file_length_q;

	// Stream position state.
	logic [OFF_W-1:0]   off_q;
	logic [CHUNK_W-1:0] cur_chunk_q;
	logic [CPG_W-1:0]   cig_q;
	logic [GROUP_W-1:0] cur_group_q;
	logic [POS_W-1:0]   pos_q;

	// Stage 1: memory read in flight.
	logic               v_s1;
	logic [BYTE_W-1:0]  d_s1;
	logic               real_s1;
	logic [CHUNK_W-1:0] chunk_s1;
	logic [OFF_W-1:0]   off_s1;
	logic [AW-1:0]      addr_s1;
	logic               dend_s1;
	logic               glast_s1;
	logic [GROUP_W-1:0] group_s1;
	logic               pend_s1;
	logic               first_s1;
	logic               fwd_s1;
	logic [BYTE_W-1:0]  rdata_s1;

	// Output register.
	logic               out_v_q;
	logic               dvalid_q;
	logic [BYTE_W-1:0]  dout_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic [OFF_W-1:0]   boff_q;
	logic               dend_q;
	logic               pvalid_q;
	logic [BYTE_W-1:0]  pout_q;
	logic [GROUP_W-1:0] group_q;
	logic               pend_q;

	logic [BYTE_W-1:0]  wdata_q;
	logic [BYTE_W-1:0]  mem [MAX_CHUNK];

	logic              acc;
	logic              adv;
	logic              wr_en;
	logic [CW-1:0]     cb_c;
	logic [CW-1:0]     off_c;
	logic [CPG_W-1:0]  cpg_c;
	logic [AW-1:0]     addr_c;
	logic              real_c;
	logic              chunk_last_c;
	logic              group_last_c;
	logic              pos_end_c;
	logic [BYTE_W-1:0] d_c;
	logic [BYTE_W-1:0] prev_s1;
	logic [BYTE_W-1:0] p_s1;

	// Handshake: stage 1 moves on when the output register is free or drained.
	assign adv           = !out_v_q || res_out.ready;
	assign byte_in.ready = !v_s1 || adv;
	assign acc           = byte_in.valid && byte_in.ready;
	assign wr_en         = v_s1 && adv;

	// Effective chunk size, group size and offset, then the boundary decisions.
	always_comb begin
		cb_c = CW'(chunk_bytes_q);
		if (cb_c == '0) begin
			cb_c = CW'(1);
		end else if (cb_c > CB_MAX) begin
			cb_c = CB_MAX;
		end
		off_c = CW'(off_q);
		if (off_c > OFF_MAX) begin
			off_c = OFF_MAX;
		end
		cpg_c = (chunks_per_group_q == '0) ? CPG_W'(1) : chunks_per_group_q;
		addr_c = off_c[AW-1:0];
		real_c = pos_q < file_length_q;
		pos_end_c = ({1'b0, pos_q} + (POS_W+1)'(1)) == {1'b0, file_length_q};
		chunk_last_c = off_c >= (cb_c - CW'(1));
		group_last_c = (cig_q >= (cpg_c - CPG_W'(1))) ||
			(({1'b0, cur_chunk_q} + (CHUNK_W+1)'(1)) == {1'b0, chunk_total_q});
		d_c = real_c ? byte_in.file_byte : '0;
	end

	// Parity update: the first chunk of a group starts the XOR fresh.
	assign prev_s1 = fwd_s1 ? wdata_q : rdata_s1;
	assign p_s1    = first_s1 ? d_s1 : (prev_s1 ^ d_s1);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_bytes_q      <= CHUNK_BYTES_RST;
			chunks_per_group_q <= CHUNKS_PER_GROUP_RST;
			chunk_total_q      <= CHUNK_TOTAL_RST;
			file_length_q      <= FILE_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_CHUNK_BYTES: begin
					chunk_bytes_q <= cfg_wdata[OFF_W-1:0];
				end
				REG_CHUNKS_PER_GROUP: begin
					chunks_per_group_q <= cfg_wdata[CPG_W-1:0];
				end
				REG_CHUNK_TOTAL: begin
					chunk_total_q <= cfg_wdata[CHUNK_W-1:0];
				end
				REG_FILE_LENGTH: begin
					file_length_q <= cfg_wdata[POS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Counters advance on every byte transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q       <= '0;
			cur_chunk_q <= '0;
			cig_q       <= '0;
			cur_group_q <= '0;
			pos_q       <= '0;
		end else if (acc) begin
			pos_q <= pos_q + POS_W'(1);
			if (chunk_last_c) begin
				off_q       <= '0;
				cur_chunk_q <= cur_chunk_q + CHUNK_W'(1);
				if (group_last_c) begin
					cig_q       <= '0;
					cur_group_q <= cur_group_q + GROUP_W'(1);
				end else begin
					cig_q <= cig_q + CPG_W'(1);
				end
			end else begin
				off_q <= OFF_W'(off_c + CW'(1));
			end
		end
	end

	// Stage 1 valid and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_v_q <= v_s1;
			end
		end
	end

	// Stage 1 payload; flag a read that misses the write landing on the same edge.
	always_ff @(posedge clk) begin
		if (acc) begin
			d_s1     <= d_c;
			real_s1  <= real_c;
			chunk_s1 <= cur_chunk_q;
			off_s1   <= OFF_W'(off_c);
			addr_s1  <= addr_c;
			dend_s1  <= real_c && (chunk_last_c || pos_end_c);
			glast_s1 <= group_last_c;
			group_s1 <= cur_group_q;
			pend_s1  <= group_last_c && chunk_last_c;
			first_s1 <= cig_q == '0;
			fwd_s1   <= wr_en && (addr_s1 == addr_c);
		end
	end

	// Parity memory: one read at the transfer, one write as stage 1 retires.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s1] <= p_s1;
			wdata_q      <= p_s1;
		end
		if (acc) begin
			rdata_s1 <= mem[addr_c];
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			dvalid_q <= real_s1;
			dout_q   <= d_s1;
			chunk_q  <= chunk_s1;
			boff_q   <= off_s1;
			dend_q   <= dend_s1;
			pvalid_q <= glast_s1;
			pout_q   <= glast_s1 ? p_s1 : '0;
			group_q  <= glast_s1 ? group_s1 : '0;
			pend_q   <= pend_s1;
		end
	end

	assign res_out.valid        = out_v_q;
	assign res_out.data_valid   = dvalid_q;
	assign res_out.data_out     = dout_q;
	assign res_out.chunk_number = chunk_q;
	assign res_out.byte_offset  = boff_q;
	assign res_out.data_end     = dend_q;
	assign res_out.parity_valid = pvalid_q;
	assign res_out.parity_out   = pout_q;
	assign res_out.group_number = group_q;
	assign res_out.parity_end   = pend_q;

endmodule : group_xor_parity_chunker

`default_nettype wire

>>> design/gxpc_checker.sv
// Port-level assertions for the chunker's result stream, bound to the top level.
// Depends on gxpc_pkg and group_xor_parity_chunker.
`default_nettype none

module gxpc_checker import gxpc_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic               data_valid,
	input wire logic [BYTE_W-1:0]  data_out,
	input wire logic               data_end,
	input wire logic               parity_valid,
	input wire logic [BYTE_W-1:0]  parity_out,
	input wire logic [GROUP_W-1:0] group_number,
	input wire logic               parity_end
);

	// A stalled result keeps its valid, its data byte and its parity byte.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(parity_out) && $stable(data_out))
		else $error("result changed while stalled");

	// A packet end is only marked on a byte of that packet.
	a_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!data_end || data_valid) && (!parity_end || parity_valid))
		else $error("end mark without its valid flag");

	// Padding bytes carry zero data.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !data_valid |-> data_out == '0)
		else $error("padding byte is not zero");

	// Without parity the parity fields read zero.
	a_no_parity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !parity_valid |-> parity_out == '0 && group_number == '0)
		else $error("parity fields set without parity");

endmodule : gxpc_checker

bind group_xor_parity_chunker gxpc_checker u_gxpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (res_out.valid),
	.out_ready    (res_out.ready),
	.data_valid   (res_out.data_valid),
	.data_out     (res_out.data_out),
	.data_end     (res_out.data_end),
	.parity_valid (res_out.parity_valid),
	.parity_out   (res_out.parity_out),
	.group_number (res_out.group_number),
	.parity_end   (res_out.parity_end)
);

`default_nettype wire

>>> tb/sv/group_xor_parity_chunker_tb.sv
// Self-checking testbench for the group XOR parity chunker: directed and random
// file byte streams under several register settings, checked against a predictor.
// Depends on gxpc_pkg, the gxpc_in_if/gxpc_out_if interfaces and the chunker RTL.
`timescale 1ns / 100ps

module group_xor_parity_chunker_tb;
	import gxpc_pkg::*;

	localparam int STORE_DEPTH  = MAX_CHUNK_DEFAULT;
	localparam int STALL_LIMIT  = 5000;
	localparam int RANDOM_ITEMS = 1375;
	localparam int SHOWN_ERRORS = 10;

	typedef struct packed {
		logic               data_valid;
		logic [BYTE_W-1:0]  data_out;
		logic [CHUNK_W-1:0] chunk_number;
		logic [OFF_W-1:0]   byte_offset;
		logic               data_end;
		logic               parity_valid;
		logic [BYTE_W-1:0]  parity_out;
		logic [GROUP_W-1:0] group_number;
		logic               parity_end;
	} chunk_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	gxpc_in_if byte_ch();
	gxpc_out_if res_ch();

	group_xor_parity_chunker DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_ch),
		.res_out  (res_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// Predictor copy of the registers.
	logic [OFF_W-1:0]   cfg_chunk_bytes;
	logic [CPG_W-1:0]   cfg_group_chunks;
	logic [CHUNK_W-1:0] cfg_chunk_total;
	logic [POS_W-1:0]   cfg_file_length;

	// Predictor copy of the block state.
	logic [BYTE_W-1:0]  parity_mem [0:STORE_DEPTH-1];
	int                 store_fill;
	logic [OFF_W-1:0]   slot_offset;
	logic [CHUNK_W-1:0] cur_chunk;
	logic [CPG_W-1:0]   group_slot;
	logic [GROUP_W-1:0] cur_group;
	logic [POS_W-1:0]   stream_pos;

	logic [BYTE_W-1:0]  file_bytes_q [$];
	chunk_result_t      pending_results [$];
	bit                 byte_taken;
	bit                 result_taken;
	int                 idle_pct;
	int                 stall_cycles;
	int                 mismatches;
	int                 results_checked;
	int                 data_bytes_seen;
	int                 parity_bytes_seen;
	int                 packet_ends_seen;
	int                 phase_count;

	// Works out the result of one file byte and advances the predicted state.
	function chunk_result_t chunker_step(input logic [BYTE_W-1:0] fb);
		chunk_result_t r;
		int cb_eff;
		int cpg_eff;
		int off;
		bit is_file_byte;
		bit chunk_last;
		bit group_last;
		logic [BYTE_W-1:0] d;
		logic [BYTE_W-1:0] p;
		cb_eff = (cfg_chunk_bytes == 0) ? 1 :
			((cfg_chunk_bytes > STORE_DEPTH) ? STORE_DEPTH : int'(cfg_chunk_bytes));
		cpg_eff = (cfg_group_chunks == 0) ? 1 : int'(cfg_group_chunks);
		off = (slot_offset >= STORE_DEPTH) ? STORE_DEPTH - 1 : int'(slot_offset);
		is_file_byte = stream_pos < cfg_file_length;
		d = is_file_byte ? fb : '0;
		chunk_last = off >= cb_eff - 1;
		group_last = (int'(group_slot) >= cpg_eff - 1) ||
			({1'b0, cur_chunk} + 33'd1 == {1'b0, cfg_chunk_total});

		// The first chunk of a group seeds the parity; later ones fold in.
		p = (group_slot == 0) ? d : (parity_mem[off] ^ d);
		parity_mem[off] = p;
		if (off + 1 > store_fill)
			store_fill = off + 1;

		r.data_valid   = is_file_byte;
		r.data_out     = d;
		r.chunk_number = cur_chunk;
		r.byte_offset  = off[OFF_W-1:0];
		r.data_end     = is_file_byte &&
			(chunk_last || ({1'b0, stream_pos} + 41'd1 == {1'b0, cfg_file_length}));
		r.parity_valid = group_last;
		r.parity_out   = group_last ? p : '0;
		r.group_number = group_last ? cur_group : '0;
		r.parity_end   = group_last && chunk_last;

		if (chunk_last) begin
			slot_offset = '0;
			cur_chunk = cur_chunk + 1;
			if (group_last) begin
				group_slot = '0;
				cur_group = cur_group + 1;
			end else begin
				group_slot = CPG_W'(group_slot + 1);
			end
		end else begin
			slot_offset = OFF_W'(off + 1);
		end
		stream_pos = stream_pos + 1;
		return r;
	endfunction

	// Writes one register and mirrors it in the predictor.
	task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (idx)
			REG_CHUNK_BYTES:      cfg_chunk_bytes = value[OFF_W-1:0];
			REG_CHUNKS_PER_GROUP: cfg_group_chunks = value[CPG_W-1:0];
			REG_CHUNK_TOTAL:      cfg_chunk_total = value[CHUNK_W-1:0];
			REG_FILE_LENGTH:      cfg_file_length = value[POS_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sets the chunk size, but never so large that a later chunk of the current
	// group would fold in a parity entry that was never written.
	task write_chunk_bytes(input int value);
		int eff;
		int v;
		v = value;
		eff = (v == 0) ? 1 : ((v > STORE_DEPTH) ? STORE_DEPTH : v);
		if (group_slot != 0 && eff > store_fill)
			v = $urandom_range(store_fill, 1);
		write_reg(REG_CHUNK_BYTES, CFG_DATA_W'(v));
	endtask

	// Pauses the feed until every expected result has come, then lets the
	// pipeline drain before registers change.
	task wait_idle();
		while (file_bytes_q.size() != 0 || pending_results.size() != 0 || byte_ch.valid)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: presents queued file bytes, holding each until its transfer.
	always @(negedge clk) begin
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
		end else if (byte_ch.valid && !byte_taken) begin
		end else if (file_bytes_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
			byte_ch.valid <= 1'b1;
			byte_ch.file_byte <= file_bytes_q[0];
		end else begin
			byte_ch.valid <= 1'b0;
		end
	end

	// Result side back-pressure.
	always @(negedge clk) begin
		res_ch.ready <= arst_n && ($urandom_range(99) >= idle_pct);
	end

	// Monitor: predicts on each byte transfer, checks each result transfer,
	// and ends the run if transfers stop.
	always @(posedge clk) begin
		chunk_result_t got;
		chunk_result_t want;
		byte_taken = arst_n && byte_ch.valid && byte_ch.ready;
		result_taken = arst_n && res_ch.valid && res_ch.ready;
		if (byte_taken) begin
			void'(file_bytes_q.pop_front());
			pending_results.push_back(chunker_step(byte_ch.file_byte));
		end
		if (result_taken) begin
			got = '{data_valid: res_ch.data_valid, data_out: res_ch.data_out,
				chunk_number: res_ch.chunk_number, byte_offset: res_ch.byte_offset,
				data_end: res_ch.data_end, parity_valid: res_ch.parity_valid,
				parity_out: res_ch.parity_out, group_number: res_ch.group_number,
				parity_end: res_ch.parity_end};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_ERRORS)
					$display("ERROR: result with none expected: chunk %0d offset %0d",
						got.chunk_number, got.byte_offset);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				data_bytes_seen += want.data_valid;
				parity_bytes_seen += want.parity_valid;
				packet_ends_seen += want.data_end + want.parity_end;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= SHOWN_ERRORS) begin
						$display("ERROR: result %0d mismatch", results_checked);
						$display("  expected dv=%b d=%h chunk=%0d off=%0d de=%b pv=%b p=%h grp=%0d pe=%b",
							want.data_valid, want.data_out, want.chunk_number,
							want.byte_offset, want.data_end, want.parity_valid,
							want.parity_out, want.group_number, want.parity_end);
						$display("  actual   dv=%b d=%h chunk=%0d off=%0d de=%b pv=%b p=%h grp=%0d pe=%b",
							got.data_valid, got.data_out, got.chunk_number,
							got.byte_offset, got.data_end, got.parity_valid,
							got.parity_out, got.group_number, got.parity_end);
					end
				end
			end
		end
		if (!arst_n || byte_taken || result_taken)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("ERROR: no transfer for %0d cycles, %0d results outstanding",
				STALL_LIMIT, pending_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Stimulus: directed settings first, then random phases.
	initial begin
		int random_items;
		int n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		byte_ch.valid = 1'b0;
		byte_ch.file_byte = '0;
		res_ch.ready = 1'b0;
		byte_taken = 1'b0;
		result_taken = 1'b0;
		idle_pct = 11;
		stall_cycles = 0;
		mismatches = 0;
		results_checked = 0;
		data_bytes_seen = 0;
		parity_bytes_seen = 0;
		packet_ends_seen = 0;
		phase_count = 0;
		random_items = 0;
		cfg_chunk_bytes = CHUNK_BYTES_RST;
		cfg_group_chunks = CHUNKS_PER_GROUP_RST;
		cfg_chunk_total = CHUNK_TOTAL_RST;
		cfg_file_length = FILE_LENGTH_RST;
		store_fill = 0;
		slot_offset = '0;
		cur_chunk = '0;
		group_slot = '0;
		cur_group = '0;
		stream_pos = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Three-byte chunks in pairs; the file ends inside the third chunk,
		// which also closes a short group at the chunk total.
		write_chunk_bytes(3);
		write_reg(REG_CHUNKS_PER_GROUP, 2);
		write_reg(REG_CHUNK_TOTAL, 3);
		write_reg(REG_FILE_LENGTH, 8);
		file_bytes_q = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F, 8'hFE,
			8'hC3, 8'h3C};
		phase_count++;

		// Zero chunk and group sizes act as one.
		wait_idle();
		write_chunk_bytes(0);
		write_reg(REG_CHUNKS_PER_GROUP, 0);
		write_reg(REG_FILE_LENGTH, {POS_W{1'b1}});
		file_bytes_q = '{8'hFF, 8'h00, 8'h96, 8'h69};
		phase_count++;

		// Oversized chunk, widest group, all-ones chunk total.
		wait_idle();
		write_chunk_bytes(16383);
		write_reg(REG_CHUNKS_PER_GROUP, 16'hFFFF);
		write_reg(REG_CHUNK_TOTAL, 32'hFFFF_FFFF);
		file_bytes_q = '{8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h11, 8'hEE};
		phase_count++;

		// Whole stream treated as padding.
		wait_idle();
		write_reg(REG_FILE_LENGTH, 0);
		file_bytes_q = '{8'hFF, 8'h12, 8'h34, 8'hFF};
		phase_count++;

		// Random phases; registers change between them with the stream mid-chunk.
		while (random_items < RANDOM_ITEMS) begin
			wait_idle();
			idle_pct = (phase_count == 8) ? 0 : 11;
			if ($urandom_range(9) < 6) begin
				case ($urandom_range(19))
					0:       write_chunk_bytes(0);
					1:       write_chunk_bytes(STORE_DEPTH);
					2:       write_chunk_bytes($urandom_range(16383, STORE_DEPTH + 1));
					3, 4:    write_chunk_bytes($urandom_range(64, 13));
					default: write_chunk_bytes($urandom_range(12, 1));
				endcase
			end
			if ($urandom_range(9) < 6) begin
				case ($urandom_range(9))
					0:       write_reg(REG_CHUNKS_PER_GROUP, 0);
					1:       write_reg(REG_CHUNKS_PER_GROUP, 16'hFFFF);
					2:       write_reg(REG_CHUNKS_PER_GROUP,
						CFG_DATA_W'($urandom_range(65535)));
					default: write_reg(REG_CHUNKS_PER_GROUP,
						CFG_DATA_W'($urandom_range(5, 1)));
				endcase
			end
			if ($urandom_range(9) < 6) begin
				case ($urandom_range(7))
					0:       write_reg(REG_CHUNK_TOTAL, 0);
					1:       write_reg(REG_CHUNK_TOTAL, 32'hFFFF_FFFF);
					2:       write_reg(REG_CHUNK_TOTAL, CFG_DATA_W'($urandom));
					default: write_reg(REG_CHUNK_TOTAL,
						CFG_DATA_W'(cur_chunk + $urandom_range(6)));
				endcase
			end
			if ($urandom_range(9) < 6) begin
				case ($urandom_range(7))
					0:       write_reg(REG_FILE_LENGTH, 0);
					1:       write_reg(REG_FILE_LENGTH, {POS_W{1'b1}});
					2:       write_reg(REG_FILE_LENGTH, {8'($urandom_range(255)), 32'($urandom)});
					3:       write_reg(REG_FILE_LENGTH,
						(stream_pos > 10) ? stream_pos - $urandom_range(10) : 0);
					default: write_reg(REG_FILE_LENGTH, stream_pos + $urandom_range(80));
				endcase
			end
			n = (phase_count == 8) ? 250 : $urandom_range(60, 1);
			repeat (n) file_bytes_q.push_back(8'($urandom_range(255)));
			random_items += n;
			phase_count++;
		end

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Covered %0d file bytes over %0d register settings: %0d data bytes,",
			results_checked, phase_count, data_bytes_seen);
		$display("%0d parity bytes, %0d packet ends, %0d groups closed.",
			parity_bytes_seen, packet_ends_seen, cur_group);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule : group_xor_parity_chunker_tb
